>>> src/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

    localparam logic [1:0] FUNC_QUERY = 2'd0;
    localparam logic [1:0] FUNC_PUSH  = 2'd1;
    localparam logic [1:0] FUNC_POP   = 2'd2;

    localparam int DATA_W = 32;
    localparam int CODE_W = 34;

    localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] EMPTY_VAL = -32'sd1;

    // stored entry: plain value or encoded minimum-setting value
    typedef logic signed [CODE_W-1:0] code_t;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        logic                     overflow;
    } out_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

>>> src/mts_cell.sv
`timescale 1ns / 1ps

module mts_cell (
    input  logic             aclk,
    input  mts_pkg::shift_t  ctl,
    input  mts_pkg::code_t   up_in,
    input  mts_pkg::code_t   dn_in,
    output mts_pkg::code_t   entry
);

    mts_pkg::code_t entry_reg;
    mts_pkg::code_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.push) begin
            entry_next = up_in;
        end else if (ctl.pop) begin
            entry_next = dn_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> src/min_tracking_stack_top.sv
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit values that reports its minimum with every item.
// Each item (query, push or pop) returns one result, registered in the cycle after
// acceptance; one item is taken per cycle for as long as results are drained. The
// stack is a row of DEPTH cells that shift down on a push and up on a pop, so the
// top two entries always sit in fixed cells and no memory port is involved; the
// longest path is the pop decode (restore minimum, then decode the new top).
// Values below the running minimum are stored encoded as 2*value - old minimum.
// Top and minimum read -1 on an empty stack, a pop on an empty stack is ignored,
// and a push on a full stack is dropped with overflow set in its result.
module min_tracking_stack_top #(
    parameter int DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mts_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mts_pkg::out_t m_data
);

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CODE_W_M1 = mts_pkg::CODE_W - 2;

    logic [CNT_W-1:0]                  fill_reg, fill_next;
    logic signed [mts_pkg::DATA_W-1:0] min_reg, min_next;
    logic                              m_valid_reg, m_valid_next;
    mts_pkg::out_t                     m_data_reg, m_data_next;

    mts_pkg::code_t  cells [DEPTH];
    mts_pkg::code_t  push_code;
    mts_pkg::shift_t shift;

    logic accept, is_empty, is_full, do_push, do_pop, dropped;
    logic push_below, pop_enc;
    logic signed [mts_pkg::DATA_W-1:0] val;
    mts_pkg::code_t val34, min34, min_next34, restored, src;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign val      = s_data.value;
    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign do_push  = accept && (s_data.func == mts_pkg::FUNC_PUSH) && !is_full;
    assign do_pop   = accept && (s_data.func == mts_pkg::FUNC_POP) && !is_empty;
    assign dropped  = (s_data.func == mts_pkg::FUNC_PUSH) && is_full;

    assign shift.push = do_push;
    assign shift.pop  = do_pop;

    assign val34 = {{2{val[31]}}, val};
    assign min34 = {{2{min_reg[31]}}, min_reg};

    assign push_below = (val < min_reg);
    assign push_code  = (!is_empty && push_below)
                        ? ({val[31], val, 1'b0} - min34) : val34;

    // pop of an encoded entry restores the previous minimum
    assign pop_enc  = (cells[0] < min34);
    assign restored = {min34[CODE_W_M1:0], 1'b0} - cells[0];

    always_comb begin
        min_next  = min_reg;
        fill_next = fill_reg;
        if (do_push) begin
            fill_next = fill_reg + CNT_W'(1);
            if (is_empty || push_below) begin
                min_next = val;
            end
        end else if (do_pop) begin
            fill_next = fill_reg - CNT_W'(1);
            if (pop_enc) begin
                min_next = restored[mts_pkg::DATA_W-1:0];
            end
        end
    end

    assign min_next34 = {{2{min_next[31]}}, min_next};

    // new top: the pushed value, the entry below a popped one, or the current top
    always_comb begin
        if (do_push) begin
            src = val34;
        end else if (do_pop) begin
            src = cells[1];
        end else begin
            src = cells[0];
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next         = 1'b1;
            m_data_next.overflow = dropped;
            if (fill_next == '0) begin
                m_data_next.top_value = mts_pkg::EMPTY_VAL;
                m_data_next.min_value = mts_pkg::EMPTY_VAL;
                m_data_next.is_empty  = 1'b1;
            end else begin
                m_data_next.top_value = (src < min_next34)
                                        ? min_next : src[mts_pkg::DATA_W-1:0];
                m_data_next.min_value = min_next;
                m_data_next.is_empty  = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            min_reg     <= mts_pkg::MIN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            mts_pkg::code_t up_in, dn_in;
            if (i == 0) begin : g_first
                assign up_in = push_code;
            end else begin : g_mid_up
                assign up_in = cells[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign dn_in = cells[i];
            end else begin : g_mid_dn
                assign dn_in = cells[i+1];
            end
            mts_cell u_cell (
                .aclk  (aclk),
                .ctl   (shift),
                .up_in (up_in),
                .dn_in (dn_in),
                .entry (cells[i])
            );
        end
    endgenerate

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/mts_checker.sv
`timescale 1ns / 1ps

module mts_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input mts_pkg::out_t m_data
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled item changed");

    a_empty_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |->
            m_data.top_value == mts_pkg::EMPTY_VAL &&
            m_data.min_value == mts_pkg::EMPTY_VAL)
        else $error("empty stack shows a value");

    a_top_ge_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_empty |-> m_data.top_value >= m_data.min_value)
        else $error("top below minimum");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> !m_data.is_empty)
        else $error("overflow on empty stack");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tb_min_tracking_stack_top.sv
`timescale 1ns / 1ps

module tb_min_tracking_stack_top;

    localparam int STACK_DEPTH  = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PRINT_LIMIT  = 100;

    localparam logic signed [mts_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [mts_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    // unused operation code; the block treats it as a query
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    mts_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    mts_pkg::out_t m_data;

    min_tracking_stack_top #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the stack, updated as each item is accepted
    mts_pkg::code_t                    shadow_codes [STACK_DEPTH];
    int                                shadow_fill;
    logic signed [mts_pkg::DATA_W-1:0] shadow_min;
    mts_pkg::out_t                     pending_results [$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    bit tx_no_idle    = 1'b0;
    bit rx_no_idle    = 1'b0;
    int hold_requests = 0;
    int holds_served  = 0;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;

    function automatic mts_pkg::code_t widen(logic signed [mts_pkg::DATA_W-1:0] v);
        return {{(mts_pkg::CODE_W-mts_pkg::DATA_W){v[mts_pkg::DATA_W-1]}}, v};
    endfunction

    function automatic mts_pkg::out_t stack_step(mts_pkg::in_t item);
        mts_pkg::out_t  res;
        mts_pkg::code_t val_code;
        mts_pkg::code_t min_code;
        mts_pkg::code_t top_code;
        mts_pkg::code_t restored;
        val_code = widen(item.value);
        min_code = widen(shadow_min);
        res = '0;
        res.top_value = mts_pkg::EMPTY_VAL;
        res.min_value = mts_pkg::EMPTY_VAL;
        case (item.func)
            mts_pkg::FUNC_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.overflow = 1'b1;
                end else if (shadow_fill == 0) begin
                    // first entry sets the minimum regardless of the stale one
                    shadow_codes[0] = val_code;
                    shadow_min = item.value;
                    shadow_fill = 1;
                end else begin
                    if (val_code < min_code) begin
                        shadow_codes[shadow_fill] = val_code + val_code - min_code;
                        shadow_min = item.value;
                    end else begin
                        shadow_codes[shadow_fill] = val_code;
                    end
                    shadow_fill++;
                end
            end
            mts_pkg::FUNC_POP: begin
                if (shadow_fill > 0) begin
                    top_code = shadow_codes[shadow_fill-1];
                    shadow_fill--;
                    if (top_code < min_code) begin
                        restored = min_code + min_code - top_code;
                        shadow_min = restored[mts_pkg::DATA_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        if (shadow_fill > 0) begin
            min_code = widen(shadow_min);
            top_code = shadow_codes[shadow_fill-1];
            res.top_value = (top_code < min_code)
                            ? shadow_min : top_code[mts_pkg::DATA_W-1:0];
            res.min_value = shadow_min;
        end
        res.is_empty = (shadow_fill == 0);
        return res;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return mts_pkg::EMPTY_VAL;
            endcase
        end
        if (r < 35) return 32'($urandom_range(0, 16)) - 32'd8;
        // land on or next to the running minimum
        if (r < 55) return shadow_min + 32'($urandom_range(0, 4)) - 32'd2;
        return $urandom();
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("%0t: %s", $time, msg);
    endtask

    // call at a rising edge; returns at the edge where the item is accepted
    task automatic send_item(input logic [1:0] func,
                             input logic signed [mts_pkg::DATA_W-1:0] value);
        mts_pkg::in_t item;
        int           gap;
        item.func  = func;
        item.value = value;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(stack_step(item));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic test_empty_stack();
        send_item(mts_pkg::FUNC_QUERY, $urandom());
        send_item(mts_pkg::FUNC_POP, $urandom());
        send_item(FUNC_SPARE, $urandom());
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_item(mts_pkg::FUNC_PUSH, VAL_MAX);
        // most negative push gives the widest encoded entry
        send_item(mts_pkg::FUNC_PUSH, VAL_MIN);
        send_item(mts_pkg::FUNC_PUSH, VAL_MIN);
        send_item(mts_pkg::FUNC_PUSH, VAL_MAX);
        send_item(mts_pkg::FUNC_PUSH, mts_pkg::EMPTY_VAL);
        send_item(FUNC_SPARE, VAL_MIN);
        send_item(mts_pkg::FUNC_POP, VAL_MIN);
        send_item(mts_pkg::FUNC_POP, '0);
        send_item(mts_pkg::FUNC_POP, VAL_MAX);
        send_item(mts_pkg::FUNC_POP, '0);
        send_item(mts_pkg::FUNC_POP, '0);
        send_item(mts_pkg::FUNC_POP, mts_pkg::EMPTY_VAL);
        wait_drained();
    endtask

    task automatic test_min_restore();
        send_item(mts_pkg::FUNC_PUSH, 32'sd10);
        send_item(mts_pkg::FUNC_PUSH, 32'sd3);
        send_item(mts_pkg::FUNC_POP, '0);
        send_item(mts_pkg::FUNC_POP, '0);
        // stack is empty but the minimum register still holds 10
        send_item(mts_pkg::FUNC_PUSH, 32'sd20);
        send_item(mts_pkg::FUNC_POP, '0);
        wait_drained();
    endtask

    task automatic test_full_stack_backpressure();
        tx_no_idle = 1'b1;
        hold_requests++;
        for (int n = 0; n < STACK_DEPTH + 4; n++) send_item(mts_pkg::FUNC_PUSH, pick_value());
        send_item(mts_pkg::FUNC_QUERY, $urandom());
        tx_no_idle = 1'b0;
        for (int n = 0; n < STACK_DEPTH + 2; n++) send_item(mts_pkg::FUNC_POP, $urandom());
        wait_drained();
    endtask

    task automatic test_random_walk();
        int          push_pct;
        int unsigned r;
        logic [1:0]  func;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0:       push_pct = 95;
                    1:       push_pct = 70;
                    2:       push_pct = 50;
                    3:       push_pct = 30;
                    default: push_pct = 5;
                endcase
                tx_no_idle = ($urandom_range(0, 3) == 0);
                rx_no_idle = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3) func = FUNC_SPARE;
            else if (r < 10) func = mts_pkg::FUNC_QUERY;
            else if ($urandom_range(0, 99) < push_pct) func = mts_pkg::FUNC_PUSH;
            else func = mts_pkg::FUNC_POP;
            send_item(func, pick_value());
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        wait_drained();
    endtask

    // result side: random stalls, plus a long hold when requested
    always @(posedge aclk) begin
        int gap;
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            rx_hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_no_idle) begin
            m_ready <= 1'b1;
        end else begin
            gap = pick_gap();
            if (gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_stall_left = gap - 1;
            end
        end
    end

    always @(posedge aclk) begin
        mts_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with no pending item: %p", m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.top_value !== want.top_value)
                    report_error($sformatf("top_value got %0d want %0d",
                                           m_data.top_value, want.top_value));
                if (m_data.min_value !== want.min_value)
                    report_error($sformatf("min_value got %0d want %0d",
                                           m_data.min_value, want.min_value));
                if (m_data.is_empty !== want.is_empty)
                    report_error($sformatf("is_empty got %b want %b",
                                           m_data.is_empty, want.is_empty));
                if (m_data.overflow !== want.overflow)
                    report_error($sformatf("overflow got %b want %b",
                                           m_data.overflow, want.overflow));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_min_tracking_stack_top: done, errors");
            $finish;
        end
    end

    initial begin
        shadow_fill = 0;
        shadow_min  = mts_pkg::MIN_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_extreme_values();
        test_min_restore();
        test_full_stack_backpressure();
        test_random_walk();

        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("tb_min_tracking_stack_top: done, clean");
        end else begin
            $display("tb_min_tracking_stack_top: done, errors");
        end
        $finish;
    end

endmodule
